>>> sv/spike_token_controller_macros.svh
// Assertion macros used by the spike token controller top module.
`ifndef SPIKE_TOKEN_CONTROLLER_MACROS_SVH
`define SPIKE_TOKEN_CONTROLLER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define STC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define STC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/stc_pkg.sv
// Shared widths, defaults and interface structs of the spike token controller.
package stc_pkg;

  localparam int NEURON_COUNT_DEF  = 256;
  localparam int AXON_COUNT_DEF    = 64;
  localparam int QUEUE_DEPTH_DEF   = 256;
  localparam int COMPUTE_DELAY_DEF = 2;

  localparam int ROW_W    = 64;
  localparam int NEURON_W = 8;
  localparam int TICK_W   = 4;

  // One queued compute record
  typedef struct packed {
    logic [NEURON_W-1:0] neuron;
    logic [ROW_W-1:0]    synapse;
    logic [ROW_W-1:0]    spike;
  } entry_t;

  // Front to queue: record to store this cycle
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // Front to back: request fields of the current request
  typedef struct packed {
    logic                sched_valid;
    logic [TICK_W-1:0]   sched_tick;
    logic                sram_valid;
    logic [NEURON_W-1:0] sram_neuron;
    logic                overflow;
  } front_res_t;

  // Queue to front and back: occupancy and head record
  typedef struct packed {
    logic   count_nz;
    logic   busy;
    logic   full;
    entry_t head;
  } queue_stat_t;

endpackage

>>> sv/spike_token_controller.sv
// Spike token controller: one request per core clock in, one result per request out.
//
// Input channel (in_valid / in_ready) carries one core clock's worth of events:
// new_tick with tick_index, and the axon spike and synapse rows that arrive.
// Output channel (res_valid / res_ready) returns exactly one result per request:
// scheduler and SRAM requests of the sweep, a compute record popped from the
// queue, and an overflow flag when a record found the queue full.
// Latency: the result of a request is presented on the cycle after acceptance.
// Throughput: one request per cycle while the result register is free or draining;
// the front logic, the queue memory and the delay counter each take the next request
// without waiting, with the queue head prefetched from its registered read port.
// A record leaves the queue COMPUTE_DELAY requests after its delay is started.
// Reset clears the sweep (idle), the hold flags, the delay counter and the queue
// pointers; queue memory is not cleared and needs no clearing pass.
// When the receiver stalls, the result register holds and in_ready drops until
// the pending result is taken; a request is taken in the same cycle it drains.
module spike_token_controller #(
  parameter int NEURON_COUNT  = stc_pkg::NEURON_COUNT_DEF,
  parameter int AXON_COUNT    = stc_pkg::AXON_COUNT_DEF,
  parameter int QUEUE_DEPTH   = stc_pkg::QUEUE_DEPTH_DEF,
  parameter int COMPUTE_DELAY = stc_pkg::COMPUTE_DELAY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          new_tick,
  input  logic [stc_pkg::TICK_W-1:0]    tick_index,
  input  logic                          axon_arrives,
  input  logic [stc_pkg::ROW_W-1:0]     axon_spikes,
  input  logic                          info_arrives,
  input  logic [stc_pkg::ROW_W-1:0]     synapse_row,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          sched_req_valid,
  output logic [stc_pkg::TICK_W-1:0]    sched_req_tick,
  output logic                          sram_req_valid,
  output logic [stc_pkg::NEURON_W-1:0]  sram_req_neuron,
  output logic                          out_valid,
  output logic [stc_pkg::NEURON_W-1:0]  out_neuron,
  output logic                          out_compute,
  output logic [stc_pkg::ROW_W-1:0]     out_synapse_row,
  output logic [stc_pkg::ROW_W-1:0]     out_axon_spikes,
  output logic                          overflow
);

`include "spike_token_controller_macros.svh"

  logic                  step_en;
  logic                  pop;
  stc_pkg::push_t        push;
  stc_pkg::front_res_t   fres;
  stc_pkg::queue_stat_t  q_stat;

  assign step_en = in_valid & in_ready;

  stc_front #(
    .NEURON_COUNT (NEURON_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .step_en      (step_en),
    .new_tick     (new_tick),
    .tick_index   (tick_index),
    .axon_arrives (axon_arrives),
    .axon_spikes  (axon_spikes),
    .info_arrives (info_arrives),
    .synapse_row  (synapse_row),
    .queue_full   (q_stat.full),
    .push         (push),
    .res          (fres)
  );

  stc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .stat (q_stat)
  );

  stc_back #(
    .AXON_COUNT    (AXON_COUNT),
    .COMPUTE_DELAY (COMPUTE_DELAY)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .step_en         (step_en),
    .fres            (fres),
    .qstat           (q_stat),
    .res_ready       (res_ready),
    .pop             (pop),
    .in_ready        (in_ready),
    .res_valid       (res_valid),
    .sched_req_valid (sched_req_valid),
    .sched_req_tick  (sched_req_tick),
    .sram_req_valid  (sram_req_valid),
    .sram_req_neuron (sram_req_neuron),
    .out_valid       (out_valid),
    .out_neuron      (out_neuron),
    .out_compute     (out_compute),
    .out_synapse_row (out_synapse_row),
    .out_axon_spikes (out_axon_spikes),
    .overflow        (overflow)
  );

  // Every accepted request yields a result on the next cycle
  `STC_ASSERT_NEXT(a_result_follows, step_en, res_valid, "accepted request gave no result")
  // A pop only happens with a stored record at the head
  `STC_ASSERT_IMPL(a_pop_nonempty, pop, q_stat.count_nz, "pop from an empty queue")
  // A dropped record means the queue really was full
  `STC_ASSERT_IMPL(a_overflow_full, step_en && fres.overflow, q_stat.full, "overflow below depth")
  // Scheduler and SRAM requests are always issued together
  `STC_ASSERT_IMPL(a_req_pair, res_valid, sram_req_valid == sched_req_valid, "request pair split")

endmodule

>>> sv/stc_front.sv
// Front part: row hold registers, neuron sweep, request issue and queue push.
module stc_front #(
  parameter int NEURON_COUNT = stc_pkg::NEURON_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step_en,
  input  logic                       new_tick,
  input  logic [stc_pkg::TICK_W-1:0] tick_index,
  input  logic                       axon_arrives,
  input  logic [stc_pkg::ROW_W-1:0]  axon_spikes,
  input  logic                       info_arrives,
  input  logic [stc_pkg::ROW_W-1:0]  synapse_row,
  input  logic                       queue_full,
  output stc_pkg::push_t             push,
  output stc_pkg::front_res_t        res
);

  localparam int SWEEP_END = 2 * NEURON_COUNT;
  localparam int SWEEP_W   = $clog2(SWEEP_END + 1);

  logic [SWEEP_W-1:0]               sweep_step;
  logic [SWEEP_W-1:0]               sweep_step_next;
  logic                             axon_hold_valid;
  logic [stc_pkg::ROW_W-1:0]        axon_hold;
  logic                             info_hold_valid;
  logic [stc_pkg::ROW_W-1:0]        info_hold;

  logic                             axon_v_eff;
  logic [stc_pkg::ROW_W-1:0]        axon_eff;
  logic                             info_v_eff;
  logic [stc_pkg::ROW_W-1:0]        info_eff;
  logic [SWEEP_W-1:0]               step_eff;
  logic                             active;
  logic                             req_step;
  logic                             take_step;
  logic [SWEEP_W+stc_pkg::NEURON_W-1:0] step_ext;
  logic [stc_pkg::NEURON_W-1:0]     neuron;

  // Merge rows arriving this cycle with the held ones
  assign axon_v_eff = axon_arrives | axon_hold_valid;
  assign axon_eff   = axon_arrives ? axon_spikes : axon_hold;
  assign info_v_eff = info_arrives | info_hold_valid;
  assign info_eff   = info_arrives ? synapse_row : info_hold;

  // Restart the sweep on a new tick and classify the step
  assign step_eff  = new_tick ? '0 : sweep_step;
  assign active    = step_eff < SWEEP_W'(SWEEP_END);
  assign req_step  = active & ~step_eff[0];
  assign take_step = active & step_eff[0] & axon_v_eff & info_v_eff;
  assign step_ext  = {{stc_pkg::NEURON_W{1'b0}}, step_eff};
  assign neuron    = step_ext[stc_pkg::NEURON_W:1];

  always_comb begin
    if (req_step || take_step) begin
      sweep_step_next = step_eff + 1'b1;
    end else if (active) begin
      sweep_step_next = step_eff;
    end else begin
      sweep_step_next = SWEEP_W'(SWEEP_END);
    end
  end

  // Push the record, or flag it when the queue has no room
  assign push.valid         = step_en & take_step & ~queue_full;
  assign push.entry.neuron  = neuron;
  assign push.entry.synapse = info_eff;
  assign push.entry.spike   = axon_eff;

  assign res.sched_valid = req_step;
  assign res.sched_tick  = req_step ? tick_index : '0;
  assign res.sram_valid  = req_step;
  assign res.sram_neuron = req_step ? neuron : '0;
  assign res.overflow    = take_step & queue_full;

  // Advance sweep and hold flags
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_step      <= SWEEP_W'(SWEEP_END);
      axon_hold_valid <= 1'b0;
      info_hold_valid <= 1'b0;
    end else if (step_en) begin
      sweep_step      <= sweep_step_next;
      axon_hold_valid <= axon_v_eff & ~take_step;
      info_hold_valid <= info_v_eff & ~take_step;
    end
  end

  // Hold row data; it is only read while its flag is set
  always_ff @(posedge clk) begin
    if (step_en) begin
      axon_hold <= axon_eff;
      info_hold <= info_eff;
    end
  end

endmodule

>>> sv/stc_queue.sv
// Record queue between front and back: memory, pointers and occupancy.
module stc_queue #(
  parameter int QUEUE_DEPTH = stc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  stc_pkg::push_t        push,
  input  logic                  pop,
  output stc_pkg::queue_stat_t  stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  stc_pkg::entry_t  mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  stc_pkg::entry_t  rd_data;
  stc_pkg::entry_t  byp_data;
  logic             byp_hit;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_next = pop ? ptr_inc(head) : head;

  assign stat.count_nz = count != '0;
  assign stat.busy     = stat.count_nz | push.valid;
  assign stat.full     = count >= CNT_W'(QUEUE_DEPTH);
  assign stat.head     = byp_hit ? byp_data : rd_data;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      if (push.valid) begin
        tail <= ptr_inc(tail);
      end
      count <= count + CNT_W'(push.valid) - CNT_W'(pop);
    end
  end

  // Write at tail, prefetch the next head, forward a same-cycle write
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[tail] <= push.entry;
    end
    rd_data  <= mem[head_next];
    byp_hit  <= push.valid && (tail == head_next);
    byp_data <= push.entry;
  end

endmodule

>>> sv/stc_back.sv
// Back part: compute delay, head pop with compute bit and result register.
module stc_back #(
  parameter int AXON_COUNT    = stc_pkg::AXON_COUNT_DEF,
  parameter int COMPUTE_DELAY = stc_pkg::COMPUTE_DELAY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_en,
  input  stc_pkg::front_res_t           fres,
  input  stc_pkg::queue_stat_t          qstat,
  input  logic                          res_ready,
  output logic                          pop,
  output logic                          in_ready,
  output logic                          res_valid,
  output logic                          sched_req_valid,
  output logic [stc_pkg::TICK_W-1:0]    sched_req_tick,
  output logic                          sram_req_valid,
  output logic [stc_pkg::NEURON_W-1:0]  sram_req_neuron,
  output logic                          out_valid,
  output logic [stc_pkg::NEURON_W-1:0]  out_neuron,
  output logic                          out_compute,
  output logic [stc_pkg::ROW_W-1:0]     out_synapse_row,
  output logic [stc_pkg::ROW_W-1:0]     out_axon_spikes,
  output logic                          overflow
);

  localparam logic [stc_pkg::ROW_W-1:0] AXON_MASK = (AXON_COUNT >= stc_pkg::ROW_W) ? '1 :
      ((stc_pkg::ROW_W'(1) << AXON_COUNT) - stc_pkg::ROW_W'(1));

  logic [1:0] delay_count;
  logic [1:0] delay_count_next;
  logic       compute;

  // Pop when the running delay reaches zero
  assign pop     = step_en & qstat.busy & (delay_count == 2'd1);
  assign compute = |(qstat.head.synapse & qstat.head.spike & AXON_MASK);

  always_comb begin
    if (!qstat.busy) begin
      delay_count_next = delay_count;
    end else if (delay_count == 2'd0) begin
      delay_count_next = 2'(COMPUTE_DELAY);
    end else begin
      delay_count_next = delay_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_count <= 2'd0;
    end else if (step_en) begin
      delay_count <= delay_count_next;
    end
  end

  // Take a new request whenever the result register is free or draining
  assign in_ready = ~rst & (~res_valid | res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step_en) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Load result fields
  always_ff @(posedge clk) begin
    if (step_en) begin
      sched_req_valid <= fres.sched_valid;
      sched_req_tick  <= fres.sched_tick;
      sram_req_valid  <= fres.sram_valid;
      sram_req_neuron <= fres.sram_neuron;
      overflow        <= fres.overflow;
      out_valid       <= pop;
      out_neuron      <= pop ? qstat.head.neuron : '0;
      out_compute     <= pop & compute;
      out_synapse_row <= pop ? qstat.head.synapse : '0;
      out_axon_spikes <= pop ? qstat.head.spike : '0;
    end
  end

endmodule

>>> tb/tb_spike_token_controller.sv
// Self-checking testbench for the spike token controller, with a per-request predictor.
`timescale 1ns / 1ps

module tb_spike_token_controller;

  localparam int NEURONS    = stc_pkg::NEURON_COUNT_DEF;
  localparam int AXONS      = stc_pkg::AXON_COUNT_DEF;
  localparam int DEPTH      = stc_pkg::QUEUE_DEPTH_DEF;
  localparam int DELAY      = stc_pkg::COMPUTE_DELAY_DEF;
  localparam int SWEEP_END  = 2 * NEURONS;
  localparam int ROW_W      = stc_pkg::ROW_W;
  localparam int NEURON_W   = stc_pkg::NEURON_W;
  localparam int TICK_W     = stc_pkg::TICK_W;
  localparam logic [ROW_W-1:0] AXON_MASK =
    (AXONS >= ROW_W) ? {ROW_W{1'b1}} : ((64'd1 << AXONS) - 64'd1);
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  // One result of the block, as seen on its output ports
  typedef struct packed {
    logic                sched_valid;
    logic [TICK_W-1:0]   sched_tick;
    logic                sram_valid;
    logic [NEURON_W-1:0] sram_neuron;
    logic                rec_valid;
    logic [NEURON_W-1:0] rec_neuron;
    logic                rec_compute;
    logic [ROW_W-1:0]    rec_synapse;
    logic [ROW_W-1:0]    rec_spikes;
    logic                dropped;
  } token_result_t;

  // Tracks the sweep, the row holds and the record queue; predicts and checks results
  class token_scoreboard;
    int unsigned     step;
    int unsigned     delay_left;
    bit              spike_held;
    bit [ROW_W-1:0]  spike_hold;
    bit              syn_held;
    bit [ROW_W-1:0]  syn_hold;
    stc_pkg::entry_t rec_mem [DEPTH];
    int unsigned     rd_ptr;
    int unsigned     wr_ptr;
    int unsigned     fill;
    token_result_t   expected_results [$];
    int              errors;
    int              n_requests;
    int              n_results;
    int              n_records;
    int              n_hits;
    int              n_drops;

    function new();
      step       = SWEEP_END;
      delay_left = 0;
      spike_held = 0;
      spike_hold = '0;
      syn_held   = 0;
      syn_hold   = '0;
      rd_ptr     = 0;
      wr_ptr     = 0;
      fill       = 0;
      errors     = 0;
      n_requests = 0;
      n_results  = 0;
      n_records  = 0;
      n_hits     = 0;
      n_drops    = 0;
    endfunction

    function bit front_idle();
      return step >= SWEEP_END;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance one core clock and return the result it causes
    function token_result_t predict_clock(logic nt, logic [TICK_W-1:0] tick, logic aa,
                                          logic [ROW_W-1:0] spikes, logic ia,
                                          logic [ROW_W-1:0] synapses);
      token_result_t r;
      int unsigned   nrn;
      r = '0;
      // latch arriving rows first
      if (aa) begin
        spike_hold = spikes;
        spike_held = 1;
      end
      if (ia) begin
        syn_hold = synapses;
        syn_held = 1;
      end
      // front: request on even steps, enqueue on odd steps once both rows are held
      if (nt) step = 0;
      if (step < SWEEP_END) begin
        nrn = step >> 1;
        if (step % 2 == 0) begin
          r.sched_valid = 1;
          r.sched_tick  = tick;
          r.sram_valid  = 1;
          r.sram_neuron = NEURON_W'(nrn);
          step++;
        end else if (spike_held && syn_held) begin
          if (fill >= DEPTH) begin
            r.dropped = 1;
          end else begin
            rec_mem[wr_ptr].neuron  = NEURON_W'(nrn);
            rec_mem[wr_ptr].synapse = syn_hold;
            rec_mem[wr_ptr].spike   = spike_hold;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            fill++;
          end
          spike_held = 0;
          syn_held   = 0;
          spike_hold = '0;
          syn_hold   = '0;
          step++;
        end
      end else begin
        step = SWEEP_END;
      end
      // back: count down the delay, pop the head when it expires
      if (fill != 0) begin
        if (delay_left == 0) begin
          delay_left = DELAY;
        end else begin
          delay_left--;
          if (delay_left == 0) begin
            r.rec_valid   = 1;
            r.rec_neuron  = rec_mem[rd_ptr].neuron;
            r.rec_synapse = rec_mem[rd_ptr].synapse;
            r.rec_spikes  = rec_mem[rd_ptr].spike;
            r.rec_compute = |(rec_mem[rd_ptr].synapse & rec_mem[rd_ptr].spike & AXON_MASK);
            rd_ptr = (rd_ptr + 1) % DEPTH;
            fill--;
          end
        end
      end
      return r;
    endfunction

    // Note an accepted request and queue its expected result
    function void note_request(logic nt, logic [TICK_W-1:0] tick, logic aa,
                               logic [ROW_W-1:0] spikes, logic ia,
                               logic [ROW_W-1:0] synapses);
      token_result_t r;
      r = predict_clock(nt, tick, aa, spikes, ia, synapses);
      n_requests++;
      if (r.rec_valid) n_records++;
      if (r.rec_valid && r.rec_compute) n_hits++;
      if (r.dropped) n_drops++;
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_field(string name, logic [ROW_W-1:0] got, logic [ROW_W-1:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %h expected %h", n_results, name, got, want));
    endtask

    // Compare an accepted result with the oldest expectation
    task check_result(token_result_t got);
      token_result_t want;
      if (expected_results.size() == 0) begin
        report("result with no request waiting");
        return;
      end
      want = expected_results.pop_front();
      check_field("sched_req_valid", got.sched_valid, want.sched_valid);
      check_field("sched_req_tick", got.sched_tick, want.sched_tick);
      check_field("sram_req_valid", got.sram_valid, want.sram_valid);
      check_field("sram_req_neuron", got.sram_neuron, want.sram_neuron);
      check_field("out_valid", got.rec_valid, want.rec_valid);
      check_field("out_neuron", got.rec_neuron, want.rec_neuron);
      check_field("out_compute", got.rec_compute, want.rec_compute);
      check_field("out_synapse_row", got.rec_synapse, want.rec_synapse);
      check_field("out_axon_spikes", got.rec_spikes, want.rec_spikes);
      check_field("overflow", got.dropped, want.dropped);
      n_results++;
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                new_tick = 1'b0;
  logic [TICK_W-1:0]   tick_index = '0;
  logic                axon_arrives = 1'b0;
  logic [ROW_W-1:0]    axon_spikes = '0;
  logic                info_arrives = 1'b0;
  logic [ROW_W-1:0]    synapse_row = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic                sched_req_valid;
  logic [TICK_W-1:0]   sched_req_tick;
  logic                sram_req_valid;
  logic [NEURON_W-1:0] sram_req_neuron;
  logic                out_valid;
  logic [NEURON_W-1:0] out_neuron;
  logic                out_compute;
  logic [ROW_W-1:0]    out_synapse_row;
  logic [ROW_W-1:0]    out_axon_spikes;
  logic                overflow;

  token_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit long_hold_req  = 0;
  int quiet_cycles   = 0;

  spike_token_controller dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .new_tick        (new_tick),
    .tick_index      (tick_index),
    .axon_arrives    (axon_arrives),
    .axon_spikes     (axon_spikes),
    .info_arrives    (info_arrives),
    .synapse_row     (synapse_row),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .sched_req_valid (sched_req_valid),
    .sched_req_tick  (sched_req_tick),
    .sram_req_valid  (sram_req_valid),
    .sram_req_neuron (sram_req_neuron),
    .out_valid       (out_valid),
    .out_neuron      (out_neuron),
    .out_compute     (out_compute),
    .out_synapse_row (out_synapse_row),
    .out_axon_spikes (out_axon_spikes),
    .overflow        (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("FAIL spike_token_controller");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: check each taken result, stall at random or for one long stretch
  initial begin : receiver
    token_result_t got;
    int            hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) begin
        got.sched_valid = sched_req_valid;
        got.sched_tick  = sched_req_tick;
        got.sram_valid  = sram_req_valid;
        got.sram_neuron = sram_req_neuron;
        got.rec_valid   = out_valid;
        got.rec_neuron  = out_neuron;
        got.rec_compute = out_compute;
        got.rec_synapse = out_synapse_row;
        got.rec_spikes  = out_axon_spikes;
        got.dropped     = overflow;
        sb.check_result(got);
      end
      if (long_hold_req && hold_left == 0) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request, hold it until taken, then note it
  task automatic send_item(logic nt, logic [TICK_W-1:0] tick, logic aa,
                           logic [ROW_W-1:0] spikes, logic ia, logic [ROW_W-1:0] synapses);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    new_tick     <= nt;
    tick_index   <= tick;
    axon_arrives <= aa;
    axon_spikes  <= spikes;
    info_arrives <= ia;
    synapse_row  <= synapses;
    do @(posedge clk); while (!in_ready);
    sb.note_request(nt, tick, aa, spikes, ia, synapses);
  endtask

  // Stop offering and wait until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [ROW_W-1:0] pick_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      3: return a & b & {$urandom, $urandom};
      default: return a;
    endcase
  endfunction

  // Mostly rows that let the sweep move on; some repeated rows and stray ticks
  task automatic send_mixed(int count);
    logic nt;
    logic aa;
    logic ia;
    repeat (count) begin
      if ($urandom_range(9) != 0) begin
        nt = sb.front_idle() ? ($urandom_range(3) == 0) : ($urandom_range(399) == 0);
        aa = ($urandom_range(99) < 60);
        ia = ($urandom_range(99) < 60);
      end else begin
        nt = ($urandom_range(7) == 0);
        aa = 1'b1;
        ia = 1'($urandom_range(1));
      end
      send_item(nt, TICK_W'($urandom_range(15)), aa, pick_row(), ia, pick_row());
    end
  endtask

  initial begin : stimulus
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: idle front, waiting odd steps, overwrite, same-clock use, restart
    send_item(0, 0, 0, '0, 0, '0);
    send_item(1, 15, 0, '0, 0, '0);
    send_item(0, 0, 0, '0, 0, '0);
    send_item(0, 0, 1, '1, 0, '0);
    send_item(0, 7, 1, 64'h8000_0000_0000_0001, 1, 64'h0000_0000_0000_0001);
    send_item(0, 10, 0, '0, 0, '0);
    send_item(0, 0, 1, '0, 1, '1);
    send_item(0, 3, 1, '1, 0, '0);
    send_item(0, 0, 0, '0, 1, '1);
    send_item(1, 5, 1, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0);
    send_item(0, 0, 0, '0, 1, 64'h5555_5555_5555_5555);
    for (i = 0; i < 6; i++) begin
      send_item(0, TICK_W'(i), 0, '0, 1, 64'd1 << (63 - i));
      send_item(0, 0, 1, 64'd1 << (63 - i), 0, '0);
    end
    drain();

    // dense sweeps back to back, the queue builds up faster than it drains
    repeat (530)
      send_item(sb.front_idle(), TICK_W'($urandom_range(15)), 1, pick_row(), 1, pick_row());
    drain();

    send_idle_pct  = 80;
    recv_stall_pct = 0;
    send_mixed(150);
    drain();

    // long receiver hold while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 80;
    long_hold_req  = 1;
    send_mixed(150);
    drain();

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    send_mixed(150);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_mixed(150);
    drain();

    repeat (8) @(posedge clk);
    $display("covered %0d requests and %0d results: %0d records out, %0d with compute set",
             sb.n_requests, sb.n_results, sb.n_records, sb.n_hits);
    $display("records dropped on a full queue: %0d, mismatches: %0d", sb.n_drops, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS spike_token_controller");
    end else begin
      $display("FAIL spike_token_controller");
    end
    $finish;
  end

endmodule
